// File: rtl/olpd_pkg.sv
`timescale 1ns / 1ps

package olpd_pkg;

    localparam int COMMAND_W  = 3;
    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 5;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;

    localparam logic [COMMAND_W-1:0] CMD_APPEND   = 3'd0;
    localparam logic [COMMAND_W-1:0] CMD_DEL_HEAD = 3'd1;
    localparam logic [COMMAND_W-1:0] CMD_DEL_TAIL = 3'd2;
    localparam logic [COMMAND_W-1:0] CMD_DEL_POS  = 3'd3;
    localparam logic [COMMAND_W-1:0] CMD_DUMP     = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [COMMAND_W-1:0]        command;
        logic signed [VALUE_W-1:0]   value;
        logic [POSITION_W-1:0]       position;
    } olpd_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]         status;
        logic [COUNT_W-1:0]          count;
        logic signed [VALUE_W-1:0]   entry_value;
        logic                        last;
    } olpd_out_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT,
        CELL_WRAP
    } olpd_cell_op_t;

    typedef enum logic {
        STATE_IDLE,
        STATE_DUMP
    } olpd_state_t;

endpackage

// File: rtl/olpd_cell.sv
`timescale 1ns / 1ps

module olpd_cell (
    input  logic                                   aclk,
    input  olpd_pkg::olpd_cell_op_t                op,
    input  logic signed [olpd_pkg::VALUE_W-1:0]    value_in,
    input  logic signed [olpd_pkg::VALUE_W-1:0]    right_in,
    input  logic signed [olpd_pkg::VALUE_W-1:0]    head_in,
    output logic signed [olpd_pkg::VALUE_W-1:0]    data_out
);

    logic signed [olpd_pkg::VALUE_W-1:0] data_reg;
    logic signed [olpd_pkg::VALUE_W-1:0] data_next;

    always_comb begin
        unique case (op)
            olpd_pkg::CELL_LOAD:  data_next = value_in;
            olpd_pkg::CELL_SHIFT: data_next = right_in;
            olpd_pkg::CELL_WRAP:  data_next = head_in;
            default:              data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

// File: rtl/ordered_list_positional_delete_top.sv
`timescale 1ns / 1ps
// ordered list of signed 32-bit entries held in a row of DEPTH cells
// input channel s_*: one command request (append, delete head, delete tail,
// delete at 1-based position, dump) per accepted request
// result channel m_*: status, count after the command, dumped entry, last flag
// the result is registered and shows in the cycle after acceptance
// throughput: one command per cycle while the receiver takes each result and
// no dump runs; every command sets the operation of all cells in parallel
// a dump of n entries emits n results by rotating the cell row one place per
// result, head cell on the output; s_ready stays low meanwhile
// a dump of an empty list gives a single empty result
// s_ready is high only with no dump running and the result register free or
// being taken, so a stalled receiver holds off new requests
// reset (aresetn low, synchronous) empties the list and drops any pending
// result; entry cells keep stale data, only the count marks what is valid
module ordered_list_positional_delete_top #(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  olpd_pkg::olpd_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output olpd_pkg::olpd_out_t m_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > olpd_pkg::POSITION_W) ? CNT_W : olpd_pkg::POSITION_W;

    olpd_pkg::olpd_state_t state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      dump_idx_reg, dump_idx_next;
    logic                  m_valid_reg, m_valid_next;
    olpd_pkg::olpd_out_t   m_data_reg, m_data_next;

    logic signed [olpd_pkg::VALUE_W-1:0] cell_data [DEPTH];
    olpd_pkg::olpd_cell_op_t             cell_op   [DEPTH];

    logic             out_free;
    logic             in_fire;
    logic [CNT_W-1:0] last_idx;
    logic             is_full;
    logic             is_empty;
    logic             dump_last;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CNT_W-1:0] del_idx;

    logic             load_en;
    logic             shift_en;
    logic             rotate_en;
    logic [CNT_W-1:0] sel_idx;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == olpd_pkg::STATE_IDLE) && out_free;
    assign in_fire   = s_valid && s_ready;
    assign last_idx  = count_reg - 1'b1;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign dump_last = (dump_idx_reg == last_idx);
    assign pos_ext   = CMP_W'(s_data.position);
    assign cnt_ext   = CMP_W'(count_reg);

    // head for position one or zero, tail at or beyond the count
    always_comb begin
        if (s_data.command == olpd_pkg::CMD_DEL_HEAD) begin
            del_idx = '0;
        end else if (s_data.command == olpd_pkg::CMD_DEL_TAIL) begin
            del_idx = last_idx;
        end else if (pos_ext <= CMP_W'(1)) begin
            del_idx = '0;
        end else if (pos_ext >= cnt_ext) begin
            del_idx = last_idx;
        end else begin
            del_idx = CNT_W'(pos_ext - CMP_W'(1));
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            olpd_pkg::STATE_IDLE: begin
                if (in_fire && s_data.command == olpd_pkg::CMD_DUMP
                    && count_reg > CNT_W'(1)) begin
                    state_next = olpd_pkg::STATE_DUMP;
                end
            end
            olpd_pkg::STATE_DUMP: begin
                if (out_free && dump_last) begin
                    state_next = olpd_pkg::STATE_IDLE;
                end
            end
            default: state_next = olpd_pkg::STATE_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        count_next    = count_reg;
        dump_idx_next = dump_idx_reg;
        load_en       = 1'b0;
        shift_en      = 1'b0;
        rotate_en     = 1'b0;
        sel_idx       = '0;

        unique case (state_reg)
            olpd_pkg::STATE_IDLE: begin
                if (in_fire) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = olpd_pkg::STAT_OK;
                    m_data_next.entry_value = '0;
                    m_data_next.last        = 1'b1;
                    case (s_data.command) inside
                        olpd_pkg::CMD_APPEND: begin
                            if (is_full) begin
                                m_data_next.status = olpd_pkg::STAT_FULL;
                            end else begin
                                load_en    = 1'b1;
                                sel_idx    = count_reg;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        olpd_pkg::CMD_DEL_HEAD, olpd_pkg::CMD_DEL_TAIL,
                        olpd_pkg::CMD_DEL_POS: begin
                            if (is_empty) begin
                                m_data_next.status = olpd_pkg::STAT_EMPTY;
                            end else begin
                                shift_en   = 1'b1;
                                sel_idx    = del_idx;
                                count_next = last_idx;
                            end
                        end
                        olpd_pkg::CMD_DUMP: begin
                            if (is_empty) begin
                                m_data_next.status = olpd_pkg::STAT_EMPTY;
                            end else begin
                                m_data_next.entry_value = cell_data[0];
                                m_data_next.last        = (count_reg == CNT_W'(1));
                                rotate_en               = 1'b1;
                                dump_idx_next           = CNT_W'(1);
                            end
                        end
                        default: ;
                    endcase
                    m_data_next.count = olpd_pkg::COUNT_W'(count_next);
                end
            end
            olpd_pkg::STATE_DUMP: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = olpd_pkg::STAT_OK;
                    m_data_next.count       = olpd_pkg::COUNT_W'(count_reg);
                    m_data_next.entry_value = cell_data[0];
                    m_data_next.last        = dump_last;
                    rotate_en               = 1'b1;
                    dump_idx_next           = dump_idx_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // per-cell operation
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (load_en && CNT_W'(i) == sel_idx) begin
                cell_op[i] = olpd_pkg::CELL_LOAD;
            end else if (shift_en && CNT_W'(i) >= sel_idx) begin
                cell_op[i] = olpd_pkg::CELL_SHIFT;
            end else if (rotate_en && CNT_W'(i) < last_idx) begin
                cell_op[i] = olpd_pkg::CELL_SHIFT;
            end else if (rotate_en && CNT_W'(i) == last_idx) begin
                cell_op[i] = olpd_pkg::CELL_WRAP;
            end else begin
                cell_op[i] = olpd_pkg::CELL_HOLD;
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == DEPTH - 1) begin : g_end
            olpd_cell u_cell (
                .aclk     (aclk),
                .op       (cell_op[g]),
                .value_in (s_data.value),
                .right_in (cell_data[g]),
                .head_in  (cell_data[0]),
                .data_out (cell_data[g])
            );
        end else begin : g_mid
            olpd_cell u_cell (
                .aclk     (aclk),
                .op       (cell_op[g]),
                .value_in (s_data.value),
                .right_in (cell_data[g+1]),
                .head_in  (cell_data[0]),
                .data_out (cell_data[g])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= olpd_pkg::STATE_IDLE;
            count_reg    <= '0;
            dump_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dump_idx_reg <= dump_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_count_only_on_request: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_fire |=> $stable(count_reg))
        else $error("entry count changed without a request");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_data.command == olpd_pkg::CMD_APPEND && !is_full
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("append did not grow the list");

    a_dump_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == olpd_pkg::STATE_DUMP |-> !s_ready)
        else $error("request taken during dump");

    a_dump_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == olpd_pkg::STATE_DUMP |-> dump_idx_reg < count_reg)
        else $error("dump index past tail");

endmodule

// File: tb/sv/ordered_list_positional_delete_top_test.sv
`timescale 1ns / 1ps

module ordered_list_positional_delete_top_test;

    localparam int DEPTH       = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_ITEMS = 104;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    olpd_pkg::olpd_in_t  s_data;
    logic                m_valid;
    logic                m_ready;
    olpd_pkg::olpd_out_t m_data;

    // shadow copy of the list contents, head at index 0
    logic signed [olpd_pkg::VALUE_W-1:0] shadow_entries[$];
    olpd_pkg::olpd_out_t                 answer_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit recv_hold      = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;

    ordered_list_positional_delete_top #(
        .DEPTH(DEPTH)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // works out the answers one accepted request causes and updates the shadow list
    function automatic void apply_list_command(input olpd_pkg::olpd_in_t req);
        olpd_pkg::olpd_out_t ans;
        int                  n;
        int                  idx;
        n          = shadow_entries.size();
        ans        = '0;
        ans.last   = 1'b1;
        case (req.command) inside
            olpd_pkg::CMD_APPEND: begin
                if (n >= DEPTH) begin
                    ans.status = olpd_pkg::STAT_FULL;
                    ans.count  = olpd_pkg::COUNT_W'(n);
                end else begin
                    shadow_entries.push_back(req.value);
                    ans.status = olpd_pkg::STAT_OK;
                    ans.count  = olpd_pkg::COUNT_W'(n + 1);
                end
                answer_q.push_back(ans);
            end
            olpd_pkg::CMD_DEL_HEAD, olpd_pkg::CMD_DEL_TAIL, olpd_pkg::CMD_DEL_POS: begin
                if (n == 0) begin
                    ans.status = olpd_pkg::STAT_EMPTY;
                    ans.count  = '0;
                end else begin
                    if (req.command == olpd_pkg::CMD_DEL_HEAD) begin
                        idx = 0;
                    end else if (req.command == olpd_pkg::CMD_DEL_TAIL) begin
                        idx = n - 1;
                    end else if (req.position <= 1) begin
                        idx = 0;
                    end else if (req.position >= n) begin
                        idx = n - 1;
                    end else begin
                        idx = req.position - 1;
                    end
                    shadow_entries.delete(idx);
                    ans.status = olpd_pkg::STAT_OK;
                    ans.count  = olpd_pkg::COUNT_W'(n - 1);
                end
                answer_q.push_back(ans);
            end
            olpd_pkg::CMD_DUMP: begin
                if (n == 0) begin
                    ans.status = olpd_pkg::STAT_EMPTY;
                    answer_q.push_back(ans);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        ans.status      = olpd_pkg::STAT_OK;
                        ans.count       = olpd_pkg::COUNT_W'(n);
                        ans.entry_value = shadow_entries[i];
                        ans.last        = (i == n - 1);
                        answer_q.push_back(ans);
                    end
                end
            end
            default: begin
                ans.status = olpd_pkg::STAT_OK;
                ans.count  = olpd_pkg::COUNT_W'(n);
                answer_q.push_back(ans);
            end
        endcase
    endfunction

    function automatic olpd_pkg::olpd_in_t list_request(
        input logic [olpd_pkg::COMMAND_W-1:0] cmd,
        input logic [olpd_pkg::VALUE_W-1:0]   val,
        input int                             pos);
        olpd_pkg::olpd_in_t req;
        req.command  = cmd;
        req.value    = val;
        req.position = olpd_pkg::POSITION_W'(pos);
        return req;
    endfunction

    function automatic olpd_pkg::olpd_in_t random_request(input int grow_pct);
        olpd_pkg::olpd_in_t req;
        int                 n;
        int                 r;
        n = shadow_entries.size();
        r = $urandom_range(99);
        if ($urandom_range(4) == 0) begin
            case ($urandom_range(3))
                0:       req.value = 32'sh8000_0000;
                1:       req.value = 32'sh7fff_ffff;
                2:       req.value = '0;
                default: req.value = '1;
            endcase
        end else begin
            req.value = $urandom;
        end
        if ($urandom_range(1) == 0) begin
            req.position = olpd_pkg::POSITION_W'($urandom_range(31));
        end else begin
            req.position = olpd_pkg::POSITION_W'($urandom_range(n + 1, 1));
        end
        if (r < 3) begin
            req.command = olpd_pkg::COMMAND_W'($urandom_range(7, 5));
        end else if (r < 12) begin
            req.command = olpd_pkg::CMD_DUMP;
        end else if ($urandom_range(99) < grow_pct) begin
            req.command = olpd_pkg::CMD_APPEND;
        end else begin
            case ($urandom_range(2))
                0:       req.command = olpd_pkg::CMD_DEL_HEAD;
                1:       req.command = olpd_pkg::CMD_DEL_TAIL;
                default: req.command = olpd_pkg::CMD_DEL_POS;
            endcase
        end
        return req;
    endfunction

    // entered and left just after a falling edge
    task automatic send_request(input olpd_pkg::olpd_in_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        apply_list_command(req);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (answer_q.size() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what,
                 $signed(got), $signed(want));
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // commands on an empty list
        send_request(list_request(olpd_pkg::CMD_DUMP, 0, 0));
        send_request(list_request(olpd_pkg::CMD_DEL_HEAD, 0, 0));
        send_request(list_request(olpd_pkg::CMD_DEL_TAIL, 0, 0));
        send_request(list_request(olpd_pkg::CMD_DEL_POS, 0, 5));
        send_request(list_request(olpd_pkg::CMD_APPEND, 32'h8000_0000, 0));
        send_request(list_request(olpd_pkg::CMD_APPEND, 32'h7fff_ffff, 0));
        send_request(list_request(olpd_pkg::CMD_APPEND, 32'h0000_0000, 0));
        send_request(list_request(olpd_pkg::CMD_APPEND, 32'hffff_ffff, 0));
        send_request(list_request(olpd_pkg::CMD_APPEND, 32'h5555_5555, 0));
        send_request(list_request(olpd_pkg::CMD_APPEND, 32'haaaa_aaaa, 0));
        send_request(list_request(olpd_pkg::CMD_DUMP, 0, 0));
        // position zero and one hit the head, past the count hits the tail
        send_request(list_request(olpd_pkg::CMD_DEL_POS, 0, 0));
        send_request(list_request(olpd_pkg::CMD_DEL_POS, 0, 1));
        send_request(list_request(olpd_pkg::CMD_DEL_POS, 0, 2));
        send_request(list_request(olpd_pkg::CMD_DEL_POS, 0, 3));
        send_request(list_request(olpd_pkg::CMD_DEL_POS, 0, 31));
        send_request(list_request(3'd5, 32'h1234_5678, 7));
        send_request(list_request(3'd6, 0, 0));
        send_request(list_request(3'd7, 32'hffff_ffff, 31));
        // removing the only entry must leave both ends empty
        send_request(list_request(olpd_pkg::CMD_DEL_HEAD, 0, 0));
        send_request(list_request(olpd_pkg::CMD_DUMP, 0, 0));
        send_request(list_request(olpd_pkg::CMD_APPEND, 123, 0));
        send_request(list_request(olpd_pkg::CMD_DEL_TAIL, 0, 0));
        send_request(list_request(olpd_pkg::CMD_APPEND, -7, 0));
        send_request(list_request(olpd_pkg::CMD_DEL_POS, 0, 16));
        send_request(list_request(olpd_pkg::CMD_DUMP, 0, 0));
    endtask

    task automatic test_random(input int items, input int idle_pct, input int stall_pct);
        int grow_pct;
        grow_pct       = 75;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < items; i++) begin
            // sweep between empty and full
            if (shadow_entries.size() >= DEPTH) begin
                grow_pct = 25;
            end else if (shadow_entries.size() == 0) begin
                grow_pct = 75;
            end
            send_request(random_request(grow_pct));
        end
    endtask

    task automatic test_backpressure_fill();
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                @(posedge aclk);
                recv_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                recv_hold = 1'b0;
            end
        join_none
        // enough appends to overflow from any starting count
        for (int i = 0; i < DEPTH + 4; i++) begin
            send_request(list_request(olpd_pkg::CMD_APPEND, $urandom, 0));
        end
        send_request(list_request(olpd_pkg::CMD_DUMP, 0, 0));
        send_request(list_request(olpd_pkg::CMD_DEL_POS, 0, 8));
        send_request(list_request(olpd_pkg::CMD_DUMP, 0, 0));
    endtask

    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 50;
        send_request(list_request(olpd_pkg::CMD_APPEND, $urandom, 0));
        send_request(list_request(olpd_pkg::CMD_DUMP, 0, 0));
        wait_drained();
        send_request(list_request(olpd_pkg::CMD_DEL_TAIL, 0, 0));
        send_request(list_request(olpd_pkg::CMD_DUMP, 0, 0));
    endtask

    always @(negedge aclk) begin
        if (recv_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        olpd_pkg::olpd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (answer_q.size() == 0) begin
                report_mismatch("unrequested result value", m_data.entry_value, 0);
            end else begin
                want = answer_q.pop_front();
                if (m_data.status !== want.status)
                    report_mismatch("status", 32'(m_data.status), 32'(want.status));
                if (m_data.count !== want.count)
                    report_mismatch("count", 32'(m_data.count), 32'(want.count));
                if (m_data.entry_value !== want.entry_value)
                    report_mismatch("entry_value", m_data.entry_value, want.entry_value);
                if (m_data.last !== want.last)
                    report_mismatch("last", 32'(m_data.last), 32'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (aresetn) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random(PHASE_ITEMS, 0, 0);
        test_backpressure_fill();
        test_random(PHASE_ITEMS, 71, 0);
        test_drain_pause();
        test_random(PHASE_ITEMS, 0, 71);
        test_random(PHASE_ITEMS, 27, 27);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: ordered_list_positional_delete_top.f
rtl/olpd_pkg.sv
rtl/olpd_cell.sv
rtl/ordered_list_positional_delete_top.sv
tb/sv/ordered_list_positional_delete_top_test.sv
